// ===== rtl/mldrnd_pkg.sv =====
`timescale 1ns / 1ps

package mldrnd_pkg;

    localparam logic [22:0] Q             = 23'd8380417;
    localparam logic [22:0] G2_SMALL      = 23'd95232;
    localparam logic [22:0] G2_LARGE      = 23'd261888;
    localparam logic [22:0] Q_MINUS_G2_SM = 23'd8285185;
    localparam logic [22:0] Q_MINUS_G2_LG = 23'd8118529;
    localparam logic [19:0] TWO_G2_SMALL  = 20'd190464;
    localparam logic [19:0] TWO_G2_LARGE  = 20'd523776;
    localparam logic [23:0] P2R_ROUND     = 24'd4095;
    localparam logic [23:0] DEC_ROUND     = 24'd127;
    localparam logic [13:0] MULT_SMALL    = 14'd11275;
    localparam logic [13:0] MULT_LARGE    = 14'd1025;
    localparam logic [30:0] BIAS_SMALL    = 31'd8388608;
    localparam logic [30:0] BIAS_LARGE    = 31'd2097152;
    localparam logic [5:0]  WRAP_SMALL    = 6'd43;
    localparam logic signed [24:0] HALF_Q = 25'sd4190208;

    localparam logic [1:0] PSET_65 = 2'd1;
    localparam logic [1:0] PSET_87 = 2'd2;

    typedef enum logic [1:0] {
        REQ_POWER2ROUND,
        REQ_DECOMPOSE,
        REQ_MAKE_HINT,
        REQ_USE_HINT
    } t_req;

    // Per-request data that rides along with the decompose stages.
    typedef struct packed {
        t_req               req;
        logic [22:0]        coeff;
        logic [16:0]        h1;
        logic               hint_in;
        logic               set44;
        logic [9:0]         p2r_high;
        logic signed [18:0] p2r_low;
        logic               hint_out;
    } t_item;

    typedef struct packed {
        logic [5:0]         high;
        logic signed [18:0] low;
    } t_split;

endpackage

// ===== rtl/mldrnd_front.sv =====
`timescale 1ns / 1ps

module mldrnd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_data,
    input  logic                 i_valid,
    input  logic [1:0]           i_req_type,
    input  logic [22:0]          i_coeff,
    input  logic [5:0]           i_high_in,
    input  logic                 i_hint_in,
    input  logic                 i_en_next,
    output logic                 o_en,
    output logic                 o_valid,
    output mldrnd_pkg::t_item    o_item
);

    logic [1:0]           r_param_set;
    logic                 r_valid;
    mldrnd_pkg::t_item    r_item;
    mldrnd_pkg::t_item    n_item;

    logic                 set44;
    logic [23:0]          p2r_sum;
    logic [10:0]          p2r_q;
    logic signed [24:0]   p2r_diff;
    logic [23:0]          dec_sum;
    logic [22:0]          g2;
    logic [22:0]          q_minus_g2;
    logic                 no_hint;

    assign o_en = !r_valid || i_en_next;

    always_comb begin
        set44 = !(r_param_set == mldrnd_pkg::PSET_65 || r_param_set == mldrnd_pkg::PSET_87);

        p2r_sum  = {1'b0, i_coeff} + mldrnd_pkg::P2R_ROUND;
        p2r_q    = p2r_sum[23:13];
        p2r_diff = $signed({2'b00, i_coeff}) - $signed({1'b0, p2r_q, 13'b0});

        dec_sum = {1'b0, i_coeff} + mldrnd_pkg::DEC_ROUND;

        g2         = set44 ? mldrnd_pkg::G2_SMALL : mldrnd_pkg::G2_LARGE;
        q_minus_g2 = set44 ? mldrnd_pkg::Q_MINUS_G2_SM : mldrnd_pkg::Q_MINUS_G2_LG;
        no_hint    = (i_coeff <= g2) || (i_coeff > q_minus_g2)
                     || (i_coeff == q_minus_g2 && i_high_in == 6'd0);

        n_item.req      = mldrnd_pkg::t_req'(i_req_type);
        n_item.coeff    = i_coeff;
        n_item.h1       = dec_sum[23:7];
        n_item.hint_in  = i_hint_in;
        n_item.set44    = set44;
        // Power2round high part can reach 1024 for out-of-range input; keep it mod 1024.
        n_item.p2r_high = p2r_q[9:0];
        n_item.p2r_low  = p2r_diff[18:0];
        n_item.hint_out = !no_hint;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param_set <= 2'd0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_param_set <= i_cfg_data;
            end
            if (o_en) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/mldrnd_decomp.sv =====
`timescale 1ns / 1ps

module mldrnd_decomp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mldrnd_pkg::t_item    i_item,
    input  logic                 i_en_next,
    output logic                 o_en,
    output logic                 o_valid,
    output mldrnd_pkg::t_item    o_item,
    output mldrnd_pkg::t_split   o_split
);

    // Stage 2: reciprocal multiply.
    logic                 r2_valid;
    mldrnd_pkg::t_item    r2_item;
    logic [30:0]          r2_prod;
    logic [30:0]          n2_prod;
    // Stage 3: quotient fold and product with 2*gamma2.
    logic                 r3_valid;
    mldrnd_pkg::t_item    r3_item;
    logic [5:0]           r3_high;
    logic [22:0]          r3_hm;
    logic [5:0]           n3_high;
    logic [22:0]          n3_hm;
    // Stage 4: centered low part.
    logic                 r4_valid;
    mldrnd_pkg::t_item    r4_item;
    mldrnd_pkg::t_split   r4_split;
    mldrnd_pkg::t_split   n4_split;

    logic                 en2;
    logic                 en3;
    logic                 en4;
    logic [13:0]          mult;
    logic [30:0]          q_sum;
    logic [6:0]           q44;
    logic [19:0]          two_g2;
    logic [25:0]          hm_full;
    logic signed [24:0]   diff;
    logic signed [24:0]   low_wide;

    assign en4  = !r4_valid || i_en_next;
    assign en3  = !r3_valid || en4;
    assign en2  = !r2_valid || en3;
    assign o_en = en2;

    always_comb begin
        mult    = i_item.set44 ? mldrnd_pkg::MULT_SMALL : mldrnd_pkg::MULT_LARGE;
        n2_prod = 31'(i_item.h1) * 31'(mult);
    end

    always_comb begin
        q_sum = r2_prod + (r2_item.set44 ? mldrnd_pkg::BIAS_SMALL : mldrnd_pkg::BIAS_LARGE);
        q44   = q_sum[30:24];
        if (r2_item.set44) begin
            // The top quotient wraps to high part zero.
            n3_high = (q44 > {1'b0, mldrnd_pkg::WRAP_SMALL}) ? 6'd0 : q44[5:0];
        end else begin
            n3_high = {2'b00, q_sum[25:22]};
        end
        two_g2  = r2_item.set44 ? mldrnd_pkg::TWO_G2_SMALL : mldrnd_pkg::TWO_G2_LARGE;
        hm_full = 26'(n3_high) * 26'(two_g2);
        n3_hm   = hm_full[22:0];
    end

    always_comb begin
        diff     = $signed({2'b00, r3_item.coeff}) - $signed({2'b00, r3_hm});
        low_wide = (diff > mldrnd_pkg::HALF_Q) ? diff - $signed({2'b00, mldrnd_pkg::Q}) : diff;
        n4_split.high = r3_high;
        n4_split.low  = low_wide[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_valid <= i_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_item <= i_item;
            r2_prod <= n2_prod;
        end
        if (en3) begin
            r3_item <= r2_item;
            r3_high <= n3_high;
            r3_hm   <= n3_hm;
        end
        if (en4) begin
            r4_item  <= r3_item;
            r4_split <= n4_split;
        end
    end

    assign o_valid = r4_valid;
    assign o_item  = r4_item;
    assign o_split = r4_split;

endmodule

// ===== rtl/mldrnd_adjust.sv =====
`timescale 1ns / 1ps

module mldrnd_adjust (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  mldrnd_pkg::t_item    i_item,
    input  mldrnd_pkg::t_split   i_split,
    input  logic                 i_stall,
    output logic                 o_en,
    output logic                 o_valid,
    output logic [9:0]           o_high_part,
    output logic signed [18:0]   o_low_part,
    output logic                 o_hint_out
);

    logic                 r_valid;
    logic [9:0]           r_high;
    logic signed [18:0]   r_low;
    logic                 r_hint;
    logic [9:0]           n_high;
    logic signed [18:0]   n_low;
    logic                 n_hint;

    logic                 low_pos;
    logic [5:0]           h;
    logic [5:0]           h_up;
    logic [5:0]           h_dn;
    logic [5:0]           h_used;

    assign o_en = !r_valid || !i_stall;

    always_comb begin
        h       = i_split.high;
        low_pos = !i_split.low[18] && (i_split.low != 19'sd0);
        if (i_item.set44) begin
            h_up = (h == mldrnd_pkg::WRAP_SMALL) ? 6'd0 : h + 6'd1;
            h_dn = (h == 6'd0) ? mldrnd_pkg::WRAP_SMALL : h - 6'd1;
        end else begin
            h_up = {2'b00, h[3:0] + 4'd1};
            h_dn = {2'b00, h[3:0] - 4'd1};
        end
        if (i_item.hint_in) begin
            h_used = low_pos ? h_up : h_dn;
        end else begin
            h_used = h;
        end

        n_high = 10'd0;
        n_low  = 19'sd0;
        n_hint = 1'b0;
        case (i_item.req)
            mldrnd_pkg::REQ_POWER2ROUND: begin
                n_high = i_item.p2r_high;
                n_low  = i_item.p2r_low;
            end
            mldrnd_pkg::REQ_DECOMPOSE: begin
                n_high = {4'b0000, h};
                n_low  = i_split.low;
            end
            mldrnd_pkg::REQ_MAKE_HINT: begin
                n_hint = i_item.hint_out;
            end
            default: begin
                n_high = {4'b0000, h_used};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_high <= n_high;
            r_low  <= n_low;
            r_hint <= n_hint;
        end
    end

    assign o_valid     = r_valid;
    assign o_high_part = r_high;
    assign o_low_part  = r_low;
    assign o_hint_out  = r_hint;

endmodule

// ===== rtl/mldsa_rounding_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while i_stall is low; the five register stages
// (input, multiply, quotient fold, low part, output) each advance independently, so
// bubbles close up. Reset is synchronous and active low; it empties every stage and
// sets the parameter set to 44.

module mldsa_rounding_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [22:0]          i_coeff,
    input  logic [5:0]           i_high_in,
    input  logic                 i_hint_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [9:0]           o_high_part,
    output logic signed [18:0]   o_low_part,
    output logic                 o_hint_out
);

    logic                 en1;
    logic                 en2;
    logic                 en5;
    logic                 s1_valid;
    mldrnd_pkg::t_item    s1_item;
    logic                 s4_valid;
    mldrnd_pkg::t_item    s4_item;
    mldrnd_pkg::t_split   s4_split;

    mldrnd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_coeff    (i_coeff),
        .i_high_in  (i_high_in),
        .i_hint_in  (i_hint_in),
        .i_en_next  (en2),
        .o_en       (en1),
        .o_valid    (s1_valid),
        .o_item     (s1_item)
    );

    mldrnd_decomp u_decomp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s1_valid),
        .i_item    (s1_item),
        .i_en_next (en5),
        .o_en      (en2),
        .o_valid   (s4_valid),
        .o_item    (s4_item),
        .o_split   (s4_split)
    );

    mldrnd_adjust u_adjust (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s4_valid),
        .i_item      (s4_item),
        .i_split     (s4_split),
        .i_stall     (i_stall),
        .o_en        (en5),
        .o_valid     (o_valid),
        .o_high_part (o_high_part),
        .o_low_part  (o_low_part),
        .o_hint_out  (o_hint_out)
    );

    assign o_stall = !en1;

endmodule
